### rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    // One input beat: a message byte and its flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       no_data;
    } t_in_item;

    // One output beat: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Work handed from the byte packer to the compression engine.
    typedef struct packed {
        logic [511:0] block;
        logic         emit;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_eng_state;

    typedef enum logic [1:0] {
        PK_BYTES,
        PK_PAD2
    } t_pack_state;

    localparam int unsigned ROUNDS = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### rtl/core/sha256_stream_hasher.sv
`default_nettype none
// SHA-256 stream hasher.
// Input channel: one beat per message byte (i_valid / o_stall, payload
// i_item). no_data marks a beat without a byte; last_byte ends the message.
// Output channel: eight beats per message (o_valid / i_stall, payload
// o_item), digest word 0 first, last_word set on word 7.
// Bytes are taken at one per cycle while a block fills and the packer does
// not stall. A full block goes through a two-entry queue to the compression
// engine, which runs one round per cycle: it loads the block, runs 64 rounds
// and folds the result into the hash. The packer stalls when the queue is
// full, and while a second padding block for a final beat is pending, so
// sustained input is set by the single round unit.
// The first digest word is offered once the final block, and any blocks
// still queued ahead of it, have passed through the engine; the eight words
// then go out at one per cycle while the receiver does not stall.
// Reset restores the initial hash values and clears all counts and queues.
// While the receiver stalls, the current digest word is held, the engine
// waits, and the queue fills until the input stalls too.
module sha256_stream_hasher (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  sha256_pkg::t_in_item  i_item,
    output logic                  o_valid,
    input  wire                   i_stall,
    output sha256_pkg::t_out_item o_item
);
    import sha256_pkg::*;

    logic job_valid, q_full, q_pop, q_ne;
    t_job job_in, job_out;

    sha256_packer u_pack (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_job_valid(job_valid), .i_job_full(q_full), .o_job(job_in)
    );

    sha256_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_job(job_in), .o_full(q_full),
        .i_pop(q_pop), .o_nonempty(q_ne), .o_job(job_out)
    );

    sha256_engine u_eng (
        .i_clk, .i_rst_n, .i_job_valid(q_ne), .i_job(job_out), .o_job_pop(q_pop),
        .o_valid, .i_stall, .o_item
    );

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_valid && q_full)) else $error("queue overflow");
    // Never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && !q_ne)) else $error("queue underflow");
    // The last digest beat carries index seven.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.last_word) |-> (o_item.word_index == 3'd7))
        else $error("last word index");
endmodule
`default_nettype wire

### rtl/core/sha256_packer.sv
`default_nettype none
// Front end: packs bytes into 64-byte blocks, adds padding and the bit
// length, and hands complete blocks to the queue.
module sha256_packer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  sha256_pkg::t_in_item i_item,
    output logic                 o_job_valid,
    input  wire                  i_job_full,
    output sha256_pkg::t_job     o_job
);
    import sha256_pkg::*;

    logic [511:0] r_block;
    logic [5:0]   r_pos;
    logic [60:0]  r_count;
    t_pack_state  r_state;

    logic [511:0] blk_byte, blk_pad, blk_len;
    logic [5:0]   pos_new;
    logic [60:0]  cnt_new;
    logic         wrap;
    logic         accept;

    // A full queue or a pending second padding block holds off the next beat.
    assign o_stall = i_job_full || (r_state == PK_PAD2);
    assign accept  = i_valid && !o_stall;

    // Byte insertion, padding and length, all as one combinational view.
    always_comb begin
        blk_byte = r_block;
        pos_new  = r_pos;
        cnt_new  = r_count;
        if (!i_item.no_data) begin
            blk_byte[511 - 8 * r_pos -: 8] = i_item.data_byte;
            pos_new = r_pos + 6'd1;
            cnt_new = r_count + 61'd1;
        end
        wrap = !i_item.no_data && (pos_new == 6'd0);
        // Pad from pos_new: 0x80 then zeros to the end.
        blk_pad = blk_byte;
        for (int j = 0; j < 64; j++) begin
            if (j == int'(pos_new)) begin
                blk_pad[511 - 8 * j -: 8] = PAD_BYTE;
            end else if (j > int'(pos_new)) begin
                blk_pad[511 - 8 * j -: 8] = 8'h00;
            end
        end
        if (wrap) begin
            blk_pad = '0;
            blk_pad[511 -: 8] = PAD_BYTE;
        end
        blk_len = blk_pad;
        blk_len[63:0] = {cnt_new, 3'b000};
    end

    // Job output to the queue.
    always_comb begin
        o_job_valid = 1'b0;
        o_job.block = blk_byte;
        o_job.emit  = 1'b0;
        if (r_state == PK_PAD2) begin
            o_job_valid = !i_job_full;
            o_job.block = r_block;
            o_job.emit  = 1'b1;
        end else if (accept) begin
            if (wrap) begin
                o_job_valid = 1'b1;
                o_job.block = blk_byte;
            end else if (i_item.last_byte) begin
                o_job_valid = 1'b1;
                if (pos_new >= 6'd56) begin
                    o_job.block = blk_pad;
                end else begin
                    o_job.block = blk_len;
                    o_job.emit  = 1'b1;
                end
            end
        end
    end

    // State update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PK_BYTES;
            r_pos   <= '0;
            r_count <= '0;
        end else if (r_state == PK_PAD2) begin
            if (!i_job_full) begin
                r_state <= PK_BYTES;
            end
        end else if (accept) begin
            if (i_item.last_byte) begin
                r_pos   <= '0;
                r_count <= '0;
                if (wrap) begin
                    r_state <= PK_PAD2;
                    r_block <= blk_len;
                end else if (pos_new >= 6'd56) begin
                    r_state <= PK_PAD2;
                    r_block <= {448'd0, cnt_new, 3'b000};
                end else begin
                    r_block <= blk_byte;
                end
            end else begin
                r_block <= blk_byte;
                r_pos   <= pos_new;
                r_count <= cnt_new;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/sha256_queue.sv
`default_nettype none
// Two-entry queue of block jobs between the packer and the engine.
module sha256_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  sha256_pkg::t_job i_job,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_nonempty,
    output sha256_pkg::t_job o_job
);
    import sha256_pkg::*;

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_job      = r_slot[r_rp];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

### rtl/core/sha256_engine.sv
`default_nettype none
// Back end: one compression round per cycle, then digest emission after the final block of a message.
module sha256_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_job_valid,
    input  sha256_pkg::t_job      i_job,
    output logic                  o_job_pop,
    output logic                  o_valid,
    input  wire                   i_stall,
    output sha256_pkg::t_out_item o_item
);
    import sha256_pkg::*;

    t_eng_state   r_state, n_state;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic         r_emit;
    logic [2:0]   r_idx;

    logic [31:0] t1, t2, wn, s0, s1;

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid) n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'(ROUNDS - 1)) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_emit ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (!i_stall && r_idx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_valid            = (r_state == ST_EMIT);
        o_item.digest_word = r_h[r_idx];
        o_item.word_index  = r_idx;
        o_item.last_word   = (r_idx == 3'd7);
    end

    // Round datapath and schedule.
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_rnd] + r_w[0];
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        for (int i = 0; i < 16; i++) r_w[i] <= i_job.block[511 - 32 * i -: 32];
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_emit <= i_job.emit;
                        r_rnd  <= '0;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= wn;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= '0;
                end
                ST_EMIT: begin
                    if (!i_stall) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
